@@ hdl/scm_pkg.sv @@
package scm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 4;
	localparam int IDX_W    = 3;
	localparam int CNT_W    = 13;
	localparam int CS_W     = 29;
	localparam int XS_W     = 44;
	localparam int PROD_W   = 32;
	localparam int NUM_W    = 58;
	localparam int DEN_W    = 24;
	localparam int COV_W    = 32;
	localparam int TRI_AW   = 6;
	localparam int XS_LO_W  = 22;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ACC_ROW,
		S_ACC_RD,
		S_ACC_WR,
		S_EM_RD,
		S_EM_M1,
		S_EM_M2,
		S_EM_M3,
		S_EM_SUB,
		S_EM_DIV,
		S_EM_OUT
	} scm_state_t;

	typedef struct packed {
		logic                    tri_re;
		logic [TRI_AW-1:0]       tri_ra;
		logic                    tri_we;
		logic [TRI_AW-1:0]       tri_wa;
		logic signed [XS_W-1:0]  tri_wd;
		logic                    cs_re;
		logic [IDX_W-1:0]        cs_ra_a;
		logic [IDX_W-1:0]        cs_ra_b;
		logic                    cs_we;
		logic [IDX_W-1:0]        cs_wa;
		logic signed [CS_W-1:0]  cs_wd;
		logic                    clear;
	} scm_store_req_t;

endpackage

@@ hdl/scm_if.sv @@
interface scm_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [scm_pkg::SAMPLE_W-1:0]   sample;
	logic                                  last;
	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

interface scm_out_if;
	logic                                  valid;
	logic                                  ready;
	logic [scm_pkg::IDX_W-1:0]             row;
	logic [scm_pkg::IDX_W-1:0]             column;
	logic signed [scm_pkg::COV_W-1:0]      covariance;
	logic                                  too_few;
	logic                                  overflowed;
	logic                                  final_res;
	modport source (output valid, output row, output column, output covariance,
		output too_few, output overflowed, output final_res, input ready);
	modport sink (input valid, input row, input column, input covariance,
		input too_few, input overflowed, input final_res, output ready);
endinterface

interface scm_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [scm_pkg::CFG_W-1:0]             channel_count;
	modport source (output valid, output channel_count, input ready);
	modport sink (input valid, input channel_count, output ready);
endinterface

@@ hdl/scm_store.sv @@
module scm_store #(
	parameter int TRI_DEPTH = 36,
	parameter int CH_DEPTH  = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  scm_pkg::scm_store_req_t             req,
	output logic signed [scm_pkg::XS_W-1:0]     tri_rdata,
	output logic signed [scm_pkg::CS_W-1:0]     cs_rdata_a,
	output logic signed [scm_pkg::CS_W-1:0]     cs_rdata_b
);

	logic signed [scm_pkg::XS_W-1:0] tri_mem [TRI_DEPTH];
	logic signed [scm_pkg::CS_W-1:0] cs_mem  [CH_DEPTH];
	logic [TRI_DEPTH-1:0]            tri_vld_q;
	logic [CH_DEPTH-1:0]             cs_vld_q;
	logic signed [scm_pkg::XS_W-1:0] tri_rd_q;
	logic signed [scm_pkg::CS_W-1:0] cs_rd_a_q;
	logic signed [scm_pkg::CS_W-1:0] cs_rd_b_q;
	logic                            tri_rv_q;
	logic                            cs_rv_a_q;
	logic                            cs_rv_b_q;

	always_ff @(posedge clk) begin
		if (req.tri_we) begin
			tri_mem[req.tri_wa] <= req.tri_wd;
		end
		if (req.tri_re) begin
			tri_rd_q <= tri_mem[req.tri_ra];
		end
		if (req.cs_we) begin
			cs_mem[req.cs_wa] <= req.cs_wd;
		end
		if (req.cs_re) begin
			cs_rd_a_q <= cs_mem[req.cs_ra_a];
			cs_rd_b_q <= cs_mem[req.cs_ra_b];
		end
	end

	// Entries not written since the last clear read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tri_vld_q <= '0;
			cs_vld_q  <= '0;
			tri_rv_q  <= 1'b0;
			cs_rv_a_q <= 1'b0;
			cs_rv_b_q <= 1'b0;
		end else begin
			if (req.clear) begin
				tri_vld_q <= '0;
				cs_vld_q  <= '0;
			end else begin
				if (req.tri_we) begin
					tri_vld_q[req.tri_wa] <= 1'b1;
				end
				if (req.cs_we) begin
					cs_vld_q[req.cs_wa] <= 1'b1;
				end
			end
			if (req.tri_re) begin
				tri_rv_q <= tri_vld_q[req.tri_ra];
			end
			if (req.cs_re) begin
				cs_rv_a_q <= cs_vld_q[req.cs_ra_a];
				cs_rv_b_q <= cs_vld_q[req.cs_ra_b];
			end
		end
	end

	assign tri_rdata  = tri_rv_q  ? tri_rd_q  : '0;
	assign cs_rdata_a = cs_rv_a_q ? cs_rd_a_q : '0;
	assign cs_rdata_b = cs_rv_b_q ? cs_rd_b_q : '0;

endmodule

@@ hdl/scm_divider.sv @@
module scm_divider (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [scm_pkg::NUM_W-1:0]    num,
	input  logic [scm_pkg::DEN_W-1:0]           den,
	output logic                                done,
	output logic signed [scm_pkg::COV_W-1:0]    quotient
);

	localparam int MAG_W = scm_pkg::NUM_W - 1;
	localparam int CW    = $clog2(MAG_W);

	logic [MAG_W-1:0]          div_q;
	logic [scm_pkg::DEN_W-1:0] rem_q;
	logic [scm_pkg::DEN_W-1:0] den_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic                      neg_q;
	logic [scm_pkg::DEN_W:0]   trial;
	logic                      take;
	logic [MAG_W-1:0]          mag_in;
	logic signed [MAG_W:0]     sgn_q;

	assign mag_in = num[scm_pkg::NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
	assign trial  = {rem_q, div_q[MAG_W-1]};
	assign take   = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(MAG_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= mag_in;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[scm_pkg::NUM_W-1];
		end else if (busy_q) begin
			rem_q <= take ? scm_pkg::DEN_W'(trial - {1'b0, den_q})
			              : trial[scm_pkg::DEN_W-1:0];
			div_q <= {div_q[MAG_W-2:0], take};
		end
	end

	// Truncation toward zero: divide magnitudes, then restore the sign.
	always_comb begin
		sgn_q = neg_q ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
		if (sgn_q > $signed((MAG_W+1)'(32'sh7fffffff))) begin
			quotient = 32'sh7fffffff;
		end else if (sgn_q < -$signed((MAG_W+1)'(33'sh080000000))) begin
			quotient = 32'sh80000000;
		end else begin
			quotient = scm_pkg::COV_W'(sgn_q);
		end
	end

	assign done = done_q;

endmodule

@@ hdl/sample_covariance_matrix.sv @@
// Unbiased sample covariance matrix of a multichannel sample stream.
//
// The data channel carries one signed channel value per transfer, channel 0
// first; channel_count values make one observation. The sample flagged last
// closes the data set. Every complete observation up to MAX_OBSERVATIONS
// is folded into channel sums and upper-triangle cross-product sums kept
// in two on-chip memories. Samples are taken only while idle; completing
// an observation of C channels then runs a read-modify-write pass, a row
// step per row and a read and a write per triangle entry, through a single
// multiply-add. After the last sample the full C x C matrix leaves on the
// result channel in row-major order. Each entry passes through one read,
// three multiply steps, one subtract, the bit-serial divider (57 steps) and
// the output state; with fewer than two observations each entry goes from
// the read straight to the output and carries zero.
// The configuration channel is ready only while the block is idle.
// A stalled result holds the block in place until the transfer completes.
// Reset empties all sums, sets channel_count to 8, and the block is ready at
// once; the sums also clear after the final entry of every set.
module sample_covariance_matrix #(
	parameter int MAX_CHANNELS     = 8,
	parameter int MAX_OBSERVATIONS = 4096,
	parameter int SAMPLE_BITS      = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	scm_cfg_if.sink     cfg,
	scm_in_if.sink      data,
	scm_out_if.source   result
);

	localparam int TRI_DEPTH = (MAX_CHANNELS * (MAX_CHANNELS + 1)) / 2;
	localparam int PW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int IW        = scm_pkg::IDX_W;

	scm_pkg::scm_state_t state_q, state_d;
	scm_pkg::scm_store_req_t req;

	logic [scm_pkg::CFG_W-1:0]        cfg_q;
	logic [scm_pkg::CFG_W-1:0]        cc;
	logic [PW-1:0]                    pos_q;
	logic [scm_pkg::CNT_W-1:0]        cnt_q;
	logic                             ovf_q;
	logic                             last_q;
	logic [IW-1:0]                    r_q;
	logic [IW-1:0]                    c_q;
	logic signed [scm_pkg::SAMPLE_W-1:0] obs_q [MAX_CHANNELS];
	logic signed [scm_pkg::SAMPLE_W-1:0] obs_r_q;
	logic signed [scm_pkg::SAMPLE_W-1:0] obs_rd;
	logic [IW-1:0]                    obs_idx;
	logic signed [scm_pkg::PROD_W-1:0] prod_s1;
	logic signed [scm_pkg::XS_W-1:0]  tri_rdata;
	logic signed [scm_pkg::CS_W-1:0]  cs_rdata_a;
	logic signed [scm_pkg::CS_W-1:0]  cs_rdata_b;
	logic [scm_pkg::CNT_W+scm_pkg::XS_LO_W-1:0] pl_q;
	logic signed [scm_pkg::CNT_W+scm_pkg::XS_W-scm_pkg::XS_LO_W:0] ph_q;
	logic signed [scm_pkg::NUM_W-1:0] ss_q;
	logic [scm_pkg::DEN_W-1:0]        den_q;
	logic signed [scm_pkg::NUM_W-1:0] num;
	logic                             div_done;
	logic signed [scm_pkg::COV_W-1:0] quotient;
	logic                             in_xfer;
	logic                             out_xfer;
	logic                             obs_done;
	logic                             few;
	logic                             row_end;
	logic                             col_end;
	logic                             is_final;
	logic [IW-1:0]                    lo_idx;
	logic [IW-1:0]                    hi_idx;

	logic [IW-1:0]                    row_q;
	logic [IW-1:0]                    col_q;
	logic signed [scm_pkg::COV_W-1:0] cov_q;
	logic                             few_q;
	logic                             ovf_out_q;
	logic                             final_q;

	// Packed upper-triangle address of (r,c), r <= c, where row r holds
	// MAX_CHANNELS - r entries.
	function automatic logic [scm_pkg::TRI_AW-1:0] tri_idx(
		input logic [IW-1:0] r,
		input logic [IW-1:0] c
	);
		logic [7:0] term;
		term = 8'(r) * (8'(2 * MAX_CHANNELS - 1) - 8'(r));
		return scm_pkg::TRI_AW'((term >> 1) + 8'(c));
	endfunction

	// A count of zero means one channel; counts above the maximum saturate.
	always_comb begin
		if (cfg_q == '0) begin
			cc = scm_pkg::CFG_W'(1);
		end else if (cfg_q > scm_pkg::CFG_W'(MAX_CHANNELS)) begin
			cc = scm_pkg::CFG_W'(MAX_CHANNELS);
		end else begin
			cc = cfg_q;
		end
	end

	assign cfg.ready   = (state_q == scm_pkg::S_IDLE);
	assign data.ready  = (state_q == scm_pkg::S_IDLE);
	assign in_xfer     = data.valid && data.ready;
	assign out_xfer    = result.valid && result.ready;
	assign obs_done    = (scm_pkg::CFG_W'(pos_q) + 1'b1) >= cc;
	assign few         = cnt_q < scm_pkg::CNT_W'(2);
	assign col_end     = (scm_pkg::CFG_W'(c_q) + 1'b1) >= cc;
	assign row_end     = (scm_pkg::CFG_W'(r_q) + 1'b1) >= cc;
	assign is_final    = row_end && col_end;
	assign lo_idx      = (r_q < c_q) ? r_q : c_q;
	assign hi_idx      = (r_q < c_q) ? c_q : r_q;
	assign obs_idx     = (state_q == scm_pkg::S_ACC_ROW) ? r_q : c_q;
	assign obs_rd      = obs_q[obs_idx[PW-1:0]];

	// n*Sxy rebuilt from its two partial products, less Sx*Sy.
	assign num = (scm_pkg::NUM_W'(ph_q) <<< scm_pkg::XS_LO_W)
	           + $signed({{(scm_pkg::NUM_W-$bits(pl_q)){1'b0}}, pl_q})
	           - ss_q;

	scm_store #(
		.TRI_DEPTH(TRI_DEPTH),
		.CH_DEPTH (MAX_CHANNELS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.tri_rdata (tri_rdata),
		.cs_rdata_a(cs_rdata_a),
		.cs_rdata_b(cs_rdata_b)
	);

	scm_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == scm_pkg::S_EM_SUB),
		.num     (num),
		.den     (den_q),
		.done    (div_done),
		.quotient(quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req         = '0;
		case (state_q)
			scm_pkg::S_IDLE: begin
				if (in_xfer) begin
					if (obs_done && (32'(cnt_q) < MAX_OBSERVATIONS)) begin
						state_d = scm_pkg::S_ACC_ROW;
					end else if (data.last) begin
						state_d = scm_pkg::S_EM_RD;
					end
				end
			end
			scm_pkg::S_ACC_ROW: begin
				state_d = scm_pkg::S_ACC_RD;
			end
			scm_pkg::S_ACC_RD: begin
				req.tri_re  = 1'b1;
				req.tri_ra  = tri_idx(r_q, c_q);
				req.cs_re   = 1'b1;
				req.cs_ra_a = r_q;
				req.cs_ra_b = r_q;
				state_d     = scm_pkg::S_ACC_WR;
			end
			scm_pkg::S_ACC_WR: begin
				req.tri_we = 1'b1;
				req.tri_wa = tri_idx(r_q, c_q);
				req.tri_wd = tri_rdata + scm_pkg::XS_W'(prod_s1);
				req.cs_we  = (c_q == r_q);
				req.cs_wa  = r_q;
				req.cs_wd  = cs_rdata_a + scm_pkg::CS_W'(obs_r_q);
				if (!col_end) begin
					state_d = scm_pkg::S_ACC_RD;
				end else if (!row_end) begin
					state_d = scm_pkg::S_ACC_ROW;
				end else if (last_q) begin
					state_d = scm_pkg::S_EM_RD;
				end else begin
					state_d = scm_pkg::S_IDLE;
				end
			end
			scm_pkg::S_EM_RD: begin
				req.tri_re  = 1'b1;
				req.tri_ra  = tri_idx(lo_idx, hi_idx);
				req.cs_re   = 1'b1;
				req.cs_ra_a = r_q;
				req.cs_ra_b = c_q;
				state_d     = few ? scm_pkg::S_EM_OUT : scm_pkg::S_EM_M1;
			end
			scm_pkg::S_EM_M1: begin
				state_d = scm_pkg::S_EM_M2;
			end
			scm_pkg::S_EM_M2: begin
				state_d = scm_pkg::S_EM_M3;
			end
			scm_pkg::S_EM_M3: begin
				state_d = scm_pkg::S_EM_SUB;
			end
			scm_pkg::S_EM_SUB: begin
				state_d = scm_pkg::S_EM_DIV;
			end
			scm_pkg::S_EM_DIV: begin
				if (div_done) begin
					state_d = scm_pkg::S_EM_OUT;
				end
			end
			scm_pkg::S_EM_OUT: begin
				if (out_xfer) begin
					req.clear = final_q;
					state_d   = final_q ? scm_pkg::S_IDLE : scm_pkg::S_EM_RD;
				end
			end
			default: begin
				state_d = scm_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q  <= scm_pkg::CFG_W'(8);
			pos_q  <= '0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			last_q <= 1'b0;
			r_q    <= '0;
			c_q    <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				cfg_q <= cfg.channel_count;
			end
			case (state_q)
				scm_pkg::S_IDLE: begin
					if (in_xfer) begin
						last_q <= data.last;
						if (obs_done) begin
							pos_q <= '0;
							if (32'(cnt_q) >= MAX_OBSERVATIONS) begin
								ovf_q <= 1'b1;
							end
						end else begin
							pos_q <= PW'(pos_q + 1'b1);
						end
					end
				end
				scm_pkg::S_ACC_WR: begin
					if (!col_end) begin
						c_q <= c_q + 1'b1;
					end else if (!row_end) begin
						r_q <= r_q + 1'b1;
						c_q <= r_q + 1'b1;
					end else begin
						r_q   <= '0;
						c_q   <= '0;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				scm_pkg::S_EM_OUT: begin
					if (out_xfer) begin
						if (final_q) begin
							r_q   <= '0;
							c_q   <= '0;
							pos_q <= '0;
							cnt_q <= '0;
							ovf_q <= 1'b0;
						end else if (!col_end) begin
							c_q <= c_q + 1'b1;
						end else begin
							c_q <= '0;
							r_q <= r_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			obs_q[pos_q] <= scm_pkg::SAMPLE_W'($signed(data.sample[SAMPLE_BITS-1:0]));
		end
		if (state_q == scm_pkg::S_ACC_ROW) begin
			obs_r_q <= obs_rd;
		end
		if (state_q == scm_pkg::S_ACC_RD) begin
			prod_s1 <= obs_r_q * obs_rd;
		end
		if (state_q == scm_pkg::S_EM_RD) begin
			row_q     <= r_q;
			col_q     <= c_q;
			few_q     <= few;
			ovf_out_q <= ovf_q;
			final_q   <= is_final;
			cov_q     <= '0;
		end
		if (state_q == scm_pkg::S_EM_M1) begin
			pl_q  <= cnt_q * tri_rdata[scm_pkg::XS_LO_W-1:0];
			den_q <= scm_pkg::DEN_W'(cnt_q)
			       * (scm_pkg::DEN_W'(cnt_q) - scm_pkg::DEN_W'(1));
		end
		if (state_q == scm_pkg::S_EM_M2) begin
			ph_q <= $signed({1'b0, cnt_q}) * $signed(tri_rdata[scm_pkg::XS_W-1:scm_pkg::XS_LO_W]);
		end
		if (state_q == scm_pkg::S_EM_M3) begin
			ss_q <= cs_rdata_a * cs_rdata_b;
		end
		if ((state_q == scm_pkg::S_EM_DIV) && div_done) begin
			cov_q <= quotient;
		end
	end

	assign result.valid      = (state_q == scm_pkg::S_EM_OUT);
	assign result.row        = row_q;
	assign result.column     = col_q;
	assign result.covariance = cov_q;
	assign result.too_few    = few_q;
	assign result.overflowed = ovf_out_q;
	assign result.final_res  = final_q;

endmodule

@@ verif/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_W     = scm_pkg::SAMPLE_W;
	localparam int CFG_W        = scm_pkg::CFG_W;
	localparam int IDX_W        = scm_pkg::IDX_W;
	localparam int COV_W        = scm_pkg::COV_W;

	localparam int MAX_CH       = 8;
	localparam int MAX_OBS      = 4096;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int SETTLE_CYCLES = 200;

	// Value patterns used to fill observations.
	typedef enum int {
		VAL_FULL,
		VAL_SMALL,
		VAL_EXTREME
	} value_mode_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} sample_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         column;
		logic signed [COV_W-1:0]  covariance;
		logic                     too_few;
		logic                     overflowed;
		logic                     final_res;
	} cov_entry_t;

	logic clk;
	logic arst_n;

	scm_cfg_if cfg_ch();
	scm_in_if  data_ch();
	scm_out_if res_ch();

	sample_covariance_matrix dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.data   (data_ch),
		.result (res_ch)
	);

	// Sequence-filled stimulus queues for the drivers, and the expected entries.
	sample_item_t               pending_samples[$];
	logic [CFG_W-1:0]           pending_counts[$];
	cov_entry_t                 expected_entries[$];

	int unsigned fail_count;
	int unsigned cycle_count;
	int unsigned random_items;

	// Shadow of the block's state, updated at each accepted transfer.
	logic [CFG_W-1:0]           count_reg;
	int unsigned                obs_position;
	int unsigned                obs_kept;
	logic                       obs_dropped;
	longint                     obs_values[MAX_CH];
	longint                     chan_sums[MAX_CH];
	longint                     prod_sums[MAX_CH][MAX_CH];

	int unsigned burst_left;
	int unsigned gap_left;
	int unsigned stall_mode;
	int unsigned stall_left;

	always #2 clk = ~clk;

	// Cycle guard: a hung handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[sample_covariance_matrix] ERROR");
			$finish;
		end
	end

	function automatic int unsigned active_channels();
		if (count_reg == 0)
			return 1;
		if (count_reg > MAX_CH)
			return MAX_CH;
		return count_reg;
	endfunction

	function automatic void clear_sums();
		obs_position = 0;
		obs_kept = 0;
		obs_dropped = 1'b0;
		for (int r = 0; r < MAX_CH; r++) begin
			obs_values[r] = 0;
			chan_sums[r] = 0;
			for (int c = 0; c < MAX_CH; c++)
				prod_sums[r][c] = 0;
		end
	endfunction

	// Fold one accepted sample into the shadow sums; on the last sample of a
	// set, queue the whole matrix that the block is expected to send.
	function automatic void fold_sample(logic signed [SAMPLE_W-1:0] s, logic is_last);
		int unsigned chans;
		int unsigned pos;
		longint n;
		longint num;
		longint v;
		bit few;
		cov_entry_t e;
		chans = active_channels();
		pos = obs_position & (MAX_CH - 1);
		obs_values[pos] = s;
		if (pos + 1 >= chans) begin
			// A complete observation past the maximum is dropped, only flagged.
			if (obs_kept >= MAX_OBS) begin
				obs_dropped = 1'b1;
			end else begin
				for (int r = 0; r < chans; r++) begin
					chan_sums[r] += obs_values[r];
					for (int c = r; c < chans; c++)
						prod_sums[r][c] += obs_values[r] * obs_values[c];
				end
				obs_kept++;
			end
			obs_position = 0;
		end else begin
			obs_position = pos + 1;
		end
		if (!is_last)
			return;
		// A partial observation at the end of the set never reaches the sums.
		n = obs_kept;
		few = obs_kept < 2;
		for (int r = 0; r < chans; r++) begin
			for (int c = 0; c < chans; c++) begin
				v = 0;
				if (!few) begin
					num = n * prod_sums[r < c ? r : c][r < c ? c : r]
						- chan_sums[r] * chan_sums[c];
					v = num / (n * (n - 1));
					if (v > 64'sd2147483647)
						v = 64'sd2147483647;
					if (v < -64'sd2147483648)
						v = -64'sd2147483648;
				end
				e.row = IDX_W'(r);
				e.column = IDX_W'(c);
				e.covariance = v[COV_W-1:0];
				e.too_few = few;
				e.overflowed = obs_dropped;
				e.final_res = (r + 1 == chans) && (c + 1 == chans);
				expected_entries.push_back(e);
			end
		end
		clear_sums();
	endfunction

	// Sample driver: bursts of random length separated by random gaps. A new
	// transfer is only presented once the previous one has been taken.
	always @(posedge clk) begin
		sample_item_t it;
		if (!data_ch.valid || data_ch.ready) begin
			if (gap_left == 0 && pending_samples.size() > 0) begin
				it = pending_samples.pop_front();
				data_ch.valid <= 1'b1;
				data_ch.sample <= it.sample;
				data_ch.last <= it.last;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				data_ch.valid <= 1'b0;
				if (gap_left > 0)
					gap_left <= gap_left - 1;
			end
		end
	end

	// Configuration driver; writes are only queued while the block is idle.
	always @(posedge clk) begin
		if (!cfg_ch.valid || cfg_ch.ready) begin
			if (pending_counts.size() > 0) begin
				cfg_ch.valid <= 1'b1;
				cfg_ch.channel_count <= pending_counts.pop_front();
			end else begin
				cfg_ch.valid <= 1'b0;
			end
		end
	end

	// Result receiver: the stall pattern switches between always ready,
	// mostly ready, mostly stalled and long stall stretches.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: res_ch.ready <= 1'b1;
			1: res_ch.ready <= ($urandom_range(0, 3) != 0);
			2: res_ch.ready <= ($urandom_range(0, 3) == 0);
			default: res_ch.ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	// Monitor: every transfer on every channel is seen here, on the values
	// present before the edge, so the checks never race the drivers.
	always @(posedge clk) begin
		cov_entry_t got;
		cov_entry_t want;
		if (res_ch.valid && res_ch.ready) begin
			got.row = res_ch.row;
			got.column = res_ch.column;
			got.covariance = res_ch.covariance;
			got.too_few = res_ch.too_few;
			got.overflowed = res_ch.overflowed;
			got.final_res = res_ch.final_res;
			if (expected_entries.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected entry row %0d col %0d cov %0d",
					$time, got.row, got.column, got.covariance);
			end else begin
				want = expected_entries.pop_front();
				if (got !== want) begin
					fail_count++;
					$display("%0t: expected row %0d col %0d cov %0d few %0b ovf %0b fin %0b",
						$time, want.row, want.column, want.covariance, want.too_few,
						want.overflowed, want.final_res);
					$display("%0t: actual   row %0d col %0d cov %0d few %0b ovf %0b fin %0b",
						$time, got.row, got.column, got.covariance, got.too_few,
						got.overflowed, got.final_res);
				end
			end
		end
		// A sample taken at the same edge as a count write still sees the old
		// count.
		if (data_ch.valid && data_ch.ready)
			fold_sample(data_ch.sample, data_ch.last);
		if (cfg_ch.valid && cfg_ch.ready)
			count_reg = cfg_ch.channel_count;
	end

	function automatic logic signed [SAMPLE_W-1:0] pick_value(value_mode_t mode);
		case (mode)
			VAL_SMALL: return SAMPLE_W'($signed($urandom_range(0, 200)) - 100);
			VAL_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh0000;
					default: return 16'shFFFF;
				endcase
			end
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Queue one data set: whole observations, optionally a partial one, and
	// the last flag on the final sample. An empty set is one lone last sample.
	task automatic queue_set(int unsigned chans, int unsigned obs, int unsigned extra,
		value_mode_t mode);
		int unsigned total;
		sample_item_t it;
		total = chans * obs + extra;
		if (total == 0)
			total = 1;
		for (int unsigned i = 0; i < total; i++) begin
			it.sample = pick_value(mode);
			it.last = (i == total - 1);
			pending_samples.push_back(it);
		end
		random_items += total;
	endtask

	task automatic queue_values(logic signed [SAMPLE_W-1:0] vals[$]);
		sample_item_t it;
		foreach (vals[i]) begin
			it.sample = vals[i];
			it.last = (i == vals.size() - 1);
			pending_samples.push_back(it);
		end
	endtask

	// Wait until every sample is taken and every entry has come back, then
	// give the block time to clear its sums before anything else happens.
	task automatic drain();
		do
			@(posedge clk);
		while (pending_samples.size() != 0 || data_ch.valid || expected_entries.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(logic [CFG_W-1:0] value);
		pending_counts.push_back(value);
		do
			@(posedge clk);
		while (pending_counts.size() != 0 || cfg_ch.valid);
		repeat (4) @(posedge clk);
	endtask

	function automatic int unsigned channels_of(logic [CFG_W-1:0] value);
		if (value == 0)
			return 1;
		return (value > MAX_CH) ? MAX_CH : value;
	endfunction

	initial begin
		logic [CFG_W-1:0] counts[$];
		logic [CFG_W-1:0] cfg_value;
		int unsigned obs;
		clk = 1'b0;
		arst_n = 1'b0;
		data_ch.valid = 1'b0;
		data_ch.sample = '0;
		data_ch.last = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.channel_count = '0;
		res_ch.ready = 1'b0;
		fail_count = 0;
		cycle_count = 0;
		random_items = 0;
		burst_left = 0;
		gap_left = 0;
		stall_mode = 0;
		stall_left = 0;
		count_reg = 4'd8;
		clear_sums();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part at the reset count of eight: two observations at the
		// opposite extremes, which gives the largest magnitudes.
		queue_values({16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
			16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
			16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
			16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
		drain();

		// Two channels: a full set, then a set with a single observation
		// (too few), a lone last sample with nothing kept, and a set ending
		// on a partial observation that must be dropped.
		write_count(4'd2);
		queue_values({16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
			16'sh0000, 16'shFFFF, 16'sh0001, 16'sh0000});
		queue_values({16'sh1234, 16'shEDCB});
		queue_values({16'sh0005});
		queue_values({16'sh0003, 16'sh0004, 16'shFFF0, 16'sh0011, 16'sh7FFF});
		drain();

		// A count of zero acts as one channel, and one above the maximum acts
		// as the maximum.
		write_count(4'd0);
		queue_values({16'sh8000, 16'sh7FFF, 16'sh0000});
		drain();
		write_count(4'd15);
		queue_set(channels_of(4'd15), 2, 0, VAL_EXTREME);
		drain();

		// Random part: mostly well-formed sets with random content, sets of
		// zero or one observation and partial tails now and then. Sets of the
		// same count run back to back; a new count only goes in when idle.
		random_items = 0;
		counts = {4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd0, 4'd9, 4'd15,
			4'd1, 4'd2, 4'd3};
		while (random_items < 140) begin
			cfg_value = counts[$urandom_range(0, counts.size() - 1)];
			write_count(cfg_value);
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(0, 7))
					0: obs = $urandom_range(0, 1);
					1: obs = $urandom_range(6, 12);
					default: obs = $urandom_range(2, 5);
				endcase
				queue_set(channels_of(cfg_value), obs,
					($urandom_range(0, 4) == 0) ? $urandom_range(1, channels_of(cfg_value)) : 0,
					value_mode_t'($urandom_range(0, 2)));
			end
			drain();
		end

		// Back to the reset count so the largest setting ends the run.
		write_count(4'd8);
		queue_set(8, 3, 0, VAL_FULL);
		drain();

		if (fail_count == 0) begin
			$display("[sample_covariance_matrix] OK");
		end else begin
			$display("[sample_covariance_matrix] ERROR");
		end
		$finish;
	end

endmodule
